[design/ettc_pkg.sv]
// Shared types and constants for the encounter tracking table.
`timescale 1ns / 1ps
package ettc_pkg;

   localparam int SLOTS       = 8;
   localparam int EPH_ID_BITS = 64;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SVC_W       = 16;
   localparam int CNT_W       = 16;
   localparam int NUM_W       = 24;   // magnitude of rssi * count + rssi
   localparam int DEN_W       = CNT_W + 1;
   localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

   localparam logic [1:0] REG_SERVICE_CODE = 2'd0;
   localparam logic [1:0] REG_LOG_WAIT     = 2'd1;
   localparam logic [1:0] REG_CLOCK_START  = 2'd2;

   localparam logic FUNC_SIGHTING = 1'b0;
   localparam logic FUNC_TICK     = 1'b1;

   typedef struct packed {
      logic [EPH_ID_BITS-1:0] eph;
      logic [31:0]            beacon;
      logic [63:0]            location;
      logic [31:0]            beacon_start;
      logic [31:0]            dongle_start;
      logic [7:0]             beacon_span;
      logic [7:0]             dongle_span;
      logic signed [7:0]      rssi;
      logic [CNT_W-1:0]       count;
   } slot_rec_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [SLOT_W-1:0] idx;
   } chain_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEARCH = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_DSTART = 6'b001000,
      ST_DWAIT  = 6'b010000,
      ST_TICK   = 6'b100000
   } state_type;

endpackage

[design/ettc_cell.sv]
// One slot of the table: record storage, eph id compare stage and expiry check.
`timescale 1ns / 1ps
module ettc_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ettc_pkg::SLOT_W-1:0]  my_idx,
   input  logic [ettc_pkg::EPH_ID_BITS-1:0] key_eph,
   input  ettc_pkg::chain_type          chain_in,
   output ettc_pkg::chain_type          chain_out,
   input  logic                         wr_en,
   input  ettc_pkg::slot_rec_type       wr_rec,
   input  logic [31:0]                  now,
   input  logic [31:0]                  wait_ticks,
   output ettc_pkg::slot_rec_type       rec,
   output logic                         expired
);
   import ettc_pkg::*;

   slot_rec_type rec_ff, rec_in;
   chain_type    chain_ff, chain_in_next;
   logic [31:0]  age;
   logic         hit;

   assign hit = chain_in.valid && !chain_in.found && (rec_ff.eph == key_eph);

   always_comb begin
      rec_in = wr_en ? wr_rec : rec_ff;
      chain_in_next.valid = chain_in.valid;
      chain_in_next.found = chain_in.found | hit;
      chain_in_next.idx   = hit ? my_idx : chain_in.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff   <= '0;
         chain_ff <= '0;
      end else begin
         rec_ff   <= rec_in;
         chain_ff <= chain_in_next;
      end
   end

   assign age       = now - rec_ff.dongle_start;
   assign expired   = (rec_ff.dongle_start != 32'd0) && (age > wait_ticks);
   assign rec       = rec_ff;
   assign chain_out = chain_ff;

endmodule

[design/ettc_div.sv]
// Restoring divider, one quotient bit per cycle, for the running mean.
`timescale 1ns / 1ps
module ettc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ettc_pkg::NUM_W-1:0]  num,
   input  logic [ettc_pkg::DEN_W-1:0]  den,
   output logic                        done,
   output logic [ettc_pkg::NUM_W-1:0]  quo
);
   import ettc_pkg::*;

   logic [NUM_W-1:0]     q_ff, q_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[NUM_W-1]};
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = DIV_CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

[design/encounter_tracking_table_core.sv]
// Top level of the encounter tracking table.
//
//  channel | dir | handshake            | carries
//  req_    | in  | req_valid/req_ready  | sighting or tick item
//  rsp_    | out | rsp_valid/rsp_ready  | one log record per expired slot
//  csr_    | in  | csr_wr_en            | service code, log wait, clock start
//
// For a matched sighting the search token walks the cell row one cell a cycle,
// then the serial divider forms the mean one bit a cycle. A sighting with no
// match ends after the search. A dropped sighting ends without leaving
// ST_IDLE. A tick steps through the slots in turn and can stall on rsp_ready.
// Synchronous reset clears every slot at once. req_ready is high only between
// items.
`timescale 1ns / 1ps
module encounter_tracking_table_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [63:0]        req_eph_id,
   input  logic [31:0]        req_beacon_id,
   input  logic [63:0]        req_location_id,
   input  logic [31:0]        req_beacon_time,
   input  logic signed [7:0]  req_rssi,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_slot,
   output logic [63:0]        rsp_out_eph_id,
   output logic [31:0]        rsp_out_beacon_id,
   output logic [63:0]        rsp_out_location_id,
   output logic [31:0]        rsp_beacon_start,
   output logic [31:0]        rsp_dongle_start,
   output logic [7:0]         rsp_beacon_span,
   output logic [7:0]         rsp_dongle_span,
   output logic signed [7:0]  rsp_mean_rssi,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import ettc_pkg::*;

   state_type state_ff, state_in;

   logic [SVC_W-1:0]        svc_ff;
   logic [31:0]             wait_ff;
   logic [31:0]             clk_ff, clk_in;
   logic [SLOT_W-1:0]       ptr_ff, ptr_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;

   logic [EPH_ID_BITS-1:0]  eph_ff;
   logic [31:0]             bid_ff;
   logic [63:0]             loc_ff;
   logic [31:0]             bt_ff;
   logic signed [7:0]       r_ff;
   logic                    tok_ff, tok_in;
   logic signed [24:0]      prod_ff;
   logic                    neg_ff;

   chain_type               chain [SLOTS+1];
   slot_rec_type            recs [SLOTS];
   logic [SLOTS-1:0]        exp_vec;
   logic [SLOTS-1:0]        wr_en;
   slot_rec_type            wr_rec;
   slot_rec_type            hit_rec, new_rec, upd_rec;

   logic                    div_start, div_done;
   logic [NUM_W-1:0]        div_num, div_quo;
   logic [DEN_W-1:0]        div_den;
   logic signed [25:0]      sum;
   logic [7:0]              mean;

   logic                    rsp_valid_ff, out_free, load_out, later_exp;
   slot_rec_type            out_rec_ff;
   logic [2:0]              out_slot_ff;
   logic                    out_last_ff;
   logic                    accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign hit_rec   = recs[idx_ff];

   assign chain[0] = '{valid: tok_ff, found: 1'b0, idx: '0};

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      ettc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .my_idx     (SLOT_W'(k)),
         .key_eph    (eph_ff),
         .chain_in   (chain[k]),
         .chain_out  (chain[k+1]),
         .wr_en      (wr_en[k]),
         .wr_rec     (wr_rec),
         .now        (clk_ff),
         .wait_ticks (wait_ff),
         .rec        (recs[k]),
         .expired    (exp_vec[k])
      );
   end

   ettc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      new_rec              = '0;
      new_rec.eph          = eph_ff;
      new_rec.beacon       = bid_ff;
      new_rec.location     = loc_ff;
      new_rec.beacon_start = bt_ff;
      new_rec.dongle_start = clk_ff;
      new_rec.beacon_span  = 8'd1;
      new_rec.rssi         = r_ff;

      sum     = 26'(prod_ff) + 26'(r_ff);
      div_num = sum[25] ? NUM_W'(-sum) : NUM_W'(sum);
      div_den = DEN_W'(hit_rec.count) + 1'b1;
      mean    = neg_ff ? 8'(-div_quo[7:0]) : div_quo[7:0];

      upd_rec             = hit_rec;
      upd_rec.dongle_span = 8'(clk_ff - hit_rec.dongle_start);
      upd_rec.beacon_span = 8'(bt_ff - hit_rec.beacon_start + 32'd1);
      upd_rec.rssi        = mean;
      if (hit_rec.count != {CNT_W{1'b1}}) begin
         upd_rec.count = hit_rec.count + 1'b1;
      end

      later_exp = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         if (exp_vec[j] && (SLOT_W'(j) > idx_ff)) begin
            later_exp = 1'b1;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      clk_in    = clk_ff;
      ptr_in    = ptr_ff;
      idx_in    = idx_ff;
      tok_in    = 1'b0;
      wr_en     = '0;
      wr_rec    = new_rec;
      div_start = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_TICK) begin
                  clk_in   = clk_ff + 32'd1;
                  idx_in   = '0;
                  state_in = ST_TICK;
               end else if (req_beacon_id[31:16] == svc_ff) begin
                  tok_in   = 1'b1;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (chain[SLOTS].valid) begin
               if (chain[SLOTS].found) begin
                  idx_in   = chain[SLOTS].idx;
                  state_in = ST_MUL;
               end else begin
                  wr_en[ptr_ff] = 1'b1;
                  ptr_in   = (ptr_ff == SLOT_W'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               wr_rec         = upd_rec;
               wr_en[idx_ff]  = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (!exp_vec[idx_ff] || out_free) begin
               if (exp_vec[idx_ff]) begin
                  load_out      = 1'b1;
                  wr_rec        = '0;
                  wr_en[idx_ff] = 1'b1;
               end
               if (idx_ff == SLOT_W'(SLOTS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_wr_en && csr_index == REG_CLOCK_START) begin
         clk_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         svc_ff       <= '0;
         wait_ff      <= '0;
         clk_ff       <= '0;
         ptr_ff       <= '0;
         idx_ff       <= '0;
         tok_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clk_ff   <= clk_in;
         ptr_ff   <= ptr_in;
         idx_ff   <= idx_in;
         tok_ff   <= tok_in;
         if (csr_wr_en && csr_index == REG_SERVICE_CODE) begin
            svc_ff <= csr_wdata[SVC_W-1:0];
         end
         if (csr_wr_en && csr_index == REG_LOG_WAIT) begin
            wait_ff <= csr_wdata;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         eph_ff <= req_eph_id[EPH_ID_BITS-1:0];
         bid_ff <= req_beacon_id;
         loc_ff <= req_location_id;
         bt_ff  <= req_beacon_time;
         r_ff   <= req_rssi;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= 25'($signed(hit_rec.rssi)) * 25'($signed({1'b0, hit_rec.count}));
      end
      if (state_ff == ST_DSTART) begin
         neg_ff <= sum[25];
      end
      if (load_out) begin
         out_rec_ff  <= recs[idx_ff];
         out_slot_ff <= 3'(idx_ff);
         out_last_ff <= !later_exp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot            = out_slot_ff;
   assign rsp_out_eph_id      = 64'(out_rec_ff.eph);
   assign rsp_out_beacon_id   = out_rec_ff.beacon;
   assign rsp_out_location_id = out_rec_ff.location;
   assign rsp_beacon_start    = out_rec_ff.beacon_start;
   assign rsp_dongle_start    = out_rec_ff.dongle_start;
   assign rsp_beacon_span     = out_rec_ff.beacon_span;
   assign rsp_dongle_span     = out_rec_ff.dongle_span;
   assign rsp_mean_rssi       = out_rec_ff.rssi;
   assign rsp_last            = out_last_ff;

endmodule

[design/ettc_checker.sv]
// Port-level checks for the encounter tracking table, bound to the top level.
`timescale 1ns / 1ps
module ettc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_func,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_out_eph_id,
   input logic        rsp_last
);
   import ettc_pkg::*;

   // a stalled record holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_eph_id))
      else $error("stalled record changed");

   // sightings never start a record
   a_sight_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_SIGHTING |=> !$rose(rsp_valid))
      else $error("record after sighting");

   // more records of the tick follow, so no new item yet
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("item taken mid tick");

endmodule

bind encounter_tracking_table_core ettc_checker u_ettc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_func       (req_func),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_eph_id (rsp_out_eph_id),
   .rsp_last       (rsp_last)
);

[dv/tb_encounter_tracking_table_core.sv]
// Testbench for the encounter tracking table: random sightings and ticks against a predictor.
`timescale 1ns / 1ps
module tb_encounter_tracking_table_core;
   import ettc_pkg::*;

   typedef struct packed {
      logic        func;
      logic [63:0] eph;
      logic [31:0] bid;
      logic [63:0] loc;
      logic [31:0] bt;
      logic [7:0]  rssi;
   } item_type;

   typedef struct packed {
      logic [2:0]  slot;
      logic [63:0] eph;
      logic [31:0] bid;
      logic [63:0] loc;
      logic [31:0] bstart;
      logic [31:0] dstart;
      logic [7:0]  bspan;
      logic [7:0]  dspan;
      logic [7:0]  rssi;
      logic        last;
   } record_type;

   localparam int WATCHDOG = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic req_func = 0;
   logic [63:0] req_eph_id = 0;
   logic [31:0] req_beacon_id = 0;
   logic [63:0] req_location_id = 0;
   logic [31:0] req_beacon_time = 0;
   logic signed [7:0] req_rssi = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [2:0] rsp_slot;
   logic [63:0] rsp_out_eph_id, rsp_out_location_id;
   logic [31:0] rsp_out_beacon_id, rsp_beacon_start, rsp_dongle_start;
   logic [7:0] rsp_beacon_span, rsp_dongle_span;
   logic signed [7:0] rsp_mean_rssi;
   logic rsp_last;
   logic csr_wr_en = 0;
   logic [1:0] csr_index = 0;
   logic [31:0] csr_wdata = 0;

   encounter_tracking_table_core dut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic [15:0] m_svc;
   logic [31:0] m_wait, m_clk;
   logic [2:0]  m_ptr;
   slot_rec_type m_slot [SLOTS];

   item_type   pending_items[$];
   record_type log_records[$];
   int errors = 0, mismatches = 0, accepted = 0, records_seen = 0, ticks_sent = 0;
   int idle_cnt = 0;
   bit no_idle = 0, hold_send = 0, done = 0;
   int quiet = 0;

   function automatic void table_reset();
      m_svc = 0; m_wait = 0; m_clk = 0; m_ptr = 0;
      for (int i = 0; i < SLOTS; i++) m_slot[i] = '0;
   endfunction

   function automatic void table_apply(item_type it);
      int idx;
      int n, num, r;
      record_type rec;
      int first_rec;
      if (it.func == FUNC_SIGHTING) begin
         if (it.bid[31:16] != m_svc) return;
         idx = -1;
         for (int i = 0; i < SLOTS; i++)
            if (idx < 0 && m_slot[i].eph == it.eph) idx = i;
         if (idx < 0) begin
            idx = m_ptr;
            m_ptr = m_ptr + 1;
            m_slot[idx] = '0;
            m_slot[idx].eph = it.eph;
            m_slot[idx].beacon = it.bid;
            m_slot[idx].location = it.loc;
            m_slot[idx].beacon_start = it.bt;
            m_slot[idx].dongle_start = m_clk;
            m_slot[idx].beacon_span = 8'd1;
            m_slot[idx].rssi = it.rssi;
         end else begin
            m_slot[idx].dongle_span = 8'(m_clk - m_slot[idx].dongle_start);
            m_slot[idx].beacon_span = 8'(it.bt - m_slot[idx].beacon_start + 32'd1);
            n = m_slot[idx].count;
            r = $signed(it.rssi);
            num = $signed(m_slot[idx].rssi) * n + r;
            m_slot[idx].rssi = 8'(num / (n + 1));   // truncates toward zero
            if (m_slot[idx].count != 16'hFFFF) m_slot[idx].count++;
         end
      end else begin
         m_clk = m_clk + 1;
         first_rec = log_records.size();
         for (int i = 0; i < SLOTS; i++) begin
            if (m_slot[i].dongle_start != 0 &&
                (m_clk - m_slot[i].dongle_start) > m_wait) begin
               rec.slot = 3'(i);
               rec.eph = m_slot[i].eph;
               rec.bid = m_slot[i].beacon;
               rec.loc = m_slot[i].location;
               rec.bstart = m_slot[i].beacon_start;
               rec.dstart = m_slot[i].dongle_start;
               rec.bspan = m_slot[i].beacon_span;
               rec.dspan = m_slot[i].dongle_span;
               rec.rssi = m_slot[i].rssi;
               rec.last = 0;
               log_records.push_back(rec);
               m_slot[i] = '0;
            end
         end
         if (log_records.size() > first_rec)
            log_records[log_records.size()-1].last = 1;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            table_apply(pending_items.pop_front());
            accepted++;
         end
         if (!req_valid || req_ready) begin
            if (idle_cnt > 0) begin
               idle_cnt <= idle_cnt - 1;
               req_valid <= 0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
               idle_cnt <= $urandom_range(1, 16);
               req_valid <= 0;
            end else if (!hold_send && pending_items.size() != 0) begin
               item_type nx;
               nx = pending_items[0];
               req_valid <= 1;
               req_func <= nx.func;
               req_eph_id <= nx.eph;
               req_beacon_id <= nx.bid;
               req_location_id <= nx.loc;
               req_beacon_time <= nx.bt;
               req_rssi <= nx.rssi;
            end else
               req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            record_type got, exp;
            got = '{rsp_slot, rsp_out_eph_id, rsp_out_beacon_id, rsp_out_location_id,
                    rsp_beacon_start, rsp_dongle_start, rsp_beacon_span,
                    rsp_dongle_span, rsp_mean_rssi, rsp_last};
            records_seen++;
            if (log_records.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected log record %p", got);
            end else begin
               exp = log_records.pop_front();
               if (got !== exp) begin
                  errors++;
                  if (mismatches++ < 10) $display("record mismatch\n exp %p\n got %p", exp, got);
               end
            end
         end
         if (no_idle) rsp_ready <= 1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet >= WATCHDOG) begin
            $display("watchdog expired");
            $display("tb: failure");
            $finish;
         end
      end
   end

   // pending_items[0] is what the driver shows; after an accept the pop moves
   // the head, and the driver reads the new head in the same edge after the pop
   // because the driver block pops before reading.

   function automatic item_type make_sighting(logic [63:0] eph, logic [15:0] svc);
      item_type it;
      it.func = FUNC_SIGHTING;
      it.eph = eph;
      it.bid = {svc, 16'($urandom)};
      it.loc = {$urandom, $urandom};
      it.bt = $urandom;
      it.rssi = 8'($urandom);
      return it;
   endfunction

   function automatic item_type make_tick();
      item_type it;
      it = '0;
      it.func = FUNC_TICK;
      it.eph = {$urandom, $urandom};
      return it;
   endfunction

   task automatic drain();
      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      while (log_records.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      if (idx == REG_SERVICE_CODE) m_svc = val[15:0];
      else if (idx == REG_LOG_WAIT) m_wait = val;
      else if (idx == REG_CLOCK_START) m_clk = val;
   endtask

   initial begin
      logic [63:0] pool [6];
      logic [15:0] svc;
      table_reset();
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: extremes, zero eph on cleared slot, wrong service, clock 0 start
      csr_write(REG_SERVICE_CODE, 32'h0000);
      pending_items.push_back(make_sighting(64'h0, 16'h0));        // matches cleared slot, start 0
      pending_items.push_back(make_sighting(64'h0, 16'h0));
      pending_items.push_back(make_sighting(64'h5, 16'h1234));     // dropped
      pending_items.push_back(make_tick());
      pending_items.push_back(make_tick());
      begin
         item_type a;
         a = make_sighting(64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
         a.rssi = 8'h80; a.bid[15:0] = 16'hFFFF; a.loc = '1; a.bt = '1;
         pending_items.push_back(a);
         a.rssi = 8'h7F; a.bt = 32'h0; a.loc = '0;
         pending_items.push_back(a);
         a.rssi = 8'hFF;
         pending_items.push_back(a);
      end
      for (int i = 0; i < 9; i++) pending_items.push_back(make_sighting(64'(100 + i), 16'h0));
      pending_items.push_back(make_tick());
      pending_items.push_back(make_tick());
      drain();

      csr_write(REG_SERVICE_CODE, 32'hFFFF_FFFF);
      csr_write(REG_LOG_WAIT, 32'hFFFF_FFFF);
      csr_write(REG_CLOCK_START, 32'hFFFF_FFFE);
      pending_items.push_back(make_sighting(64'h77, 16'hFFFF));
      pending_items.push_back(make_tick());
      pending_items.push_back(make_tick());                        // clock wraps
      pending_items.push_back(make_sighting(64'h77, 16'hFFFF));
      drain();

      // random phases with varied settings
      for (int ph = 0; ph < 4; ph++) begin
         svc = (ph == 3) ? 16'h0 : 16'($urandom);
         csr_write(REG_SERVICE_CODE, {16'($urandom), svc});
         csr_write(REG_LOG_WAIT, (ph == 0) ? 32'd0 : 32'($urandom_range(1, 6)));
         csr_write(REG_CLOCK_START, (ph == 1) ? 32'hFFFF_FFF0 : 32'($urandom));
         for (int k = 0; k < 6; k++) pool[k] = {$urandom, $urandom};
         if (ph == 2) no_idle = 1;
         for (int n = 0; n < 40; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: pending_items.push_back(make_tick());
               3: pending_items.push_back(make_sighting(pool[0], 16'($urandom)));
               4: pending_items.push_back(make_sighting({$urandom, $urandom}, svc));
               default:
                  pending_items.push_back(make_sighting(pool[$urandom_range(0, 5)], svc));
            endcase
            if (n == 30) begin
               hold_send = 1;
               while (pending_items.size() != 0 || req_valid) begin
                  hold_send = 0; @(posedge clock);
               end
               hold_send = 1;
               while (log_records.size() != 0) @(posedge clock);
               hold_send = 0;
            end
         end
         for (int t = 0; t < 8; t++) pending_items.push_back(make_tick());
         drain();
         no_idle = (ph == 2);
      end
      no_idle = 1;
      for (int n = 0; n < 20; n++)
         pending_items.push_back(($urandom_range(0, 2) == 0) ? make_tick()
                                 : make_sighting({$urandom, $urandom}, svc));
      drain();

      $display("run: %0d items accepted, %0d log records checked", accepted, records_seen);
      $display("covered service filter, id matches, slot overwrite, clock wrap, expiry");
      if (errors == 0 && log_records.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
